// File: rtl/core/ctt_pkg.sv
// Shared types, constants and codes of the TCP connection tracker.
package ctt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IN_TDATA_W = 200;
  localparam int OUT_TDATA_W = 56;

  localparam logic [1:0] ST_SYN = 2'd0;
  localparam logic [1:0] ST_SYNACK = 2'd1;
  localparam logic [1:0] ST_EST = 2'd2;
  localparam logic [1:0] DIR_UNKNOWN = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic [15:0] captured_len;
    logic [15:0] payload_len;
    logic [31:0] ack_num;
    logic [31:0] seq_num;
    logic        fin_flag;
    logic        ack_flag;
    logic        syn_flag;
    logic        direction;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } in_item_t;

  typedef struct packed {
    logic        table_full;
    logic        fin_seen;
    logic [31:0] next_seq;
    logic        continuation;
    logic        became_established;
    logic        second_half;
    logic [1:0]  conn_direction;
    logic [1:0]  conn_state;
    logic [7:0]  entry_index;
    logic        hit;
  } out_item_t;

  typedef struct packed {
    logic [95:0] key;
    logic [1:0]  state;
    logic [1:0]  dir;
    logic [31:0] seq1;
    logic [31:0] seq2;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
    logic             create;
    logic             cont_nxt;
  } upd_ctl_t;

endpackage

// File: rtl/core/ctt_table_ram.sv
// Simple dual-port synchronous RAM (separate write and read ports) with registered read data.
module ctt_table_ram #(
  parameter int WIDTH = 164,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ctt_update.sv
// Connection entry update and result formation for one packet.
module ctt_update (
  input  ctt_pkg::in_item_t           item,
  input  logic                        hit,
  input  logic                        hit_second,
  input  logic [ctt_pkg::IDX_W-1:0]   hit_idx,
  input  ctt_pkg::entry_t             old_entry,
  input  logic [ctt_pkg::CNT_W-1:0]   fill,
  input  logic                        cont_flag,
  output ctt_pkg::upd_ctl_t           ctl,
  output ctt_pkg::out_item_t          res
);

  ctt_pkg::entry_t                 ne;
  logic [ctt_pkg::IDX_W-1:0]       idx;
  logic [ctt_pkg::IDX_W+7:0]       idx_ext;
  logic                            second;
  logic                            became;
  logic                            cont;
  logic                            fin_seen;
  logic                            full;
  logic                            same_dir;
  logic [31:0]                     seq_end;
  logic [95:0]                     fwd_key;
  logic [95:0]                     rev_key;

  always_comb begin
    fwd_key = {item.src_addr, item.dst_addr, item.src_port, item.dst_port};
    rev_key = {item.dst_addr, item.src_addr, item.dst_port, item.src_port};
    same_dir = (old_entry.dir == {1'b0, item.direction});
    seq_end = item.seq_num + {16'd0, item.payload_len};
    ne = old_entry;
    idx = hit_idx;
    second = hit_second;
    became = 1'b0;
    cont = 1'b0;
    fin_seen = 1'b0;
    full = 1'b0;
    ctl.cont_nxt = cont_flag;
    ctl.create = 1'b0;
    ctl.we = 1'b0;
    if (hit) begin
      ctl.we = 1'b1;
      case (old_entry.state)
        ctt_pkg::ST_SYN: begin
          if (!same_dir && item.syn_flag && item.ack_flag) begin
            ne.state = ctt_pkg::ST_SYNACK;
            ne.seq1 = old_entry.seq1 + 32'd1;
            ne.seq2 = item.seq_num;
          end
        end
        ctt_pkg::ST_SYNACK: begin
          if (same_dir && !item.syn_flag && item.ack_flag) begin
            ne.state = ctt_pkg::ST_EST;
            ne.seq2 = old_entry.seq2 + 32'd1;
            became = 1'b1;
          end
        end
        ctt_pkg::ST_EST: begin
          if (item.captured_len < item.payload_len) begin
            ctl.cont_nxt = 1'b1;
            cont = 1'b1;
          end else begin
            ctl.cont_nxt = 1'b0;
            if (hit_second) begin
              ne.seq2 = seq_end;
            end else begin
              ne.seq1 = seq_end;
            end
            fin_seen = item.fin_flag;
          end
        end
        default: begin
        end
      endcase
    end else begin
      idx = fill[ctt_pkg::IDX_W-1:0];
      full = (fill == ctt_pkg::CNT_W'(ctt_pkg::TABLE_ENTRIES));
      if (item.syn_flag && !item.ack_flag) begin
        second = 1'b0;
        ne.dir = {1'b0, item.direction};
        ne.state = ctt_pkg::ST_SYN;
        ne.seq1 = item.seq_num;
        ne.seq2 = 32'd0;
      end else if (item.syn_flag) begin
        second = 1'b1;
        ne.dir = {1'b0, ~item.direction};
        ne.state = ctt_pkg::ST_SYNACK;
        ne.seq1 = item.ack_num;
        ne.seq2 = item.seq_num;
      end else if (item.ack_flag) begin
        second = !item.direction;
        ne.dir = {1'b0, item.direction};
        ne.state = ctt_pkg::ST_EST;
        ne.seq1 = item.seq_num;
        ne.seq2 = item.ack_num;
      end else begin
        second = !item.direction;
        ne.dir = ctt_pkg::DIR_UNKNOWN;
        ne.state = ctt_pkg::ST_EST;
        ne.seq1 = item.ack_num;
        ne.seq2 = item.seq_num;
      end
      ne.key = second ? rev_key : fwd_key;
      became = (ne.state == ctt_pkg::ST_EST);
      ctl.we = !full;
      ctl.create = !full;
    end
    ctl.addr = idx;
    ctl.data = ne;
    idx_ext = {8'd0, idx};
    res = '0;
    if (full) begin
      res.table_full = 1'b1;
    end else begin
      res.hit = hit;
      res.entry_index = idx_ext[7:0];
      res.conn_state = ne.state;
      res.conn_direction = ne.dir;
      res.second_half = second;
      res.became_established = became;
      res.continuation = cont;
      res.next_seq = second ? ne.seq2 : ne.seq1;
      res.fin_seen = fin_seen;
    end
  end

endmodule

// File: rtl/core/tcp_connection_tracker_top.sv
// Each accepted packet is registered; the table RAM is then read in slot order from slot 0 and each
// stored key is compared in both directions. The scan stops at the first match or the last stored slot.
// The entry is then updated and the result registered; no new packet is accepted until then.
// Slots fill in order and are never freed, so a fill count bounds the scan.
// A full table reports table_full and stores nothing.
// Reset clears the fill count, the continuation flag and the handshake state; the RAM is not cleared.
module tcp_connection_tracker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // src_addr, dst_addr, src_port, dst_port, direction, syn, ack, fin, seq_num,
  // ack_num, payload_len, captured_len, zero pad.
  input  logic [ctt_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit, entry_index, conn_state, conn_direction, second_half, became_established,
  // continuation, next_seq, fin_seen, table_full, zero pad.
  output logic [ctt_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  ctt_pkg::ctl_state_t             state_r, state_nxt;
  ctt_pkg::in_item_t               item_r;
  ctt_pkg::out_item_t              out_r;
  ctt_pkg::out_item_t              res;
  ctt_pkg::upd_ctl_t               ctl;
  ctt_pkg::entry_t                 rd_entry;
  logic [ctt_pkg::CNT_W-1:0]       fill_r;
  logic [ctt_pkg::CNT_W-1:0]       scan_r;
  logic [ctt_pkg::IDX_W-1:0]       rd_idx_r;
  logic [ctt_pkg::IDX_W-1:0]       hit_idx_r;
  logic                            rd_pend_r;
  logic                            hit_r;
  logic                            second_r;
  logic                            cont_r;
  logic                            out_valid_r;
  logic                            fwd_m, rev_m, match;
  logic                            scan_more;
  logic                            re;
  logic                            fin_go;
  logic                            in_acc;

  assign fwd_m = rd_entry.key == {item_r.src_addr, item_r.dst_addr,
                                  item_r.src_port, item_r.dst_port};
  assign rev_m = rd_entry.key == {item_r.dst_addr, item_r.src_addr,
                                  item_r.dst_port, item_r.src_port};
  assign match = rd_pend_r && (fwd_m || rev_m);
  assign scan_more = scan_r < fill_r;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ctt_pkg::S_SCAN;
        end
      end
      ctt_pkg::S_SCAN: begin
        if (match || (!scan_more && !rd_pend_r) || (!scan_more && !match)) begin
          state_nxt = ctt_pkg::S_FIN;
        end
      end
      ctt_pkg::S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ctt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ctt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = rst_n && (state_r == ctt_pkg::S_IDLE);
    re = (state_r == ctt_pkg::S_SCAN) && !match && scan_more;
    fin_go = (state_r == ctt_pkg::S_FIN) && (!out_valid_r || out_tready);
  end

  ctt_table_ram #(
    .WIDTH($bits(ctt_pkg::entry_t)),
    .DEPTH(ctt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (fin_go && ctl.we),
    .waddr(ctl.addr),
    .wdata(ctl.data),
    .re   (re),
    .raddr(scan_r[ctt_pkg::IDX_W-1:0]),
    .rdata(rd_entry)
  );

  ctt_update u_upd (
    .item      (item_r),
    .hit       (hit_r),
    .hit_second(second_r),
    .hit_idx   (hit_idx_r),
    .old_entry (rd_entry),
    .fill      (fill_r),
    .cont_flag (cont_r),
    .ctl       (ctl),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctt_pkg::S_IDLE;
      fill_r <= '0;
      cont_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      rd_pend_r <= re;
      if (in_acc) begin
        scan_r <= '0;
      end else if (re) begin
        scan_r <= scan_r + 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_go) begin
        cont_r <= ctl.cont_nxt;
        if (ctl.create) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_tdata[$bits(ctt_pkg::in_item_t)-1:0];
      hit_r <= 1'b0;
    end
    if (re) begin
      rd_idx_r <= scan_r[ctt_pkg::IDX_W-1:0];
    end
    if ((state_r == ctt_pkg::S_SCAN) && match) begin
      hit_r <= 1'b1;
      second_r <= !fwd_m;
      hit_idx_r <= rd_idx_r;
    end
    if (fin_go) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(ctt_pkg::OUT_TDATA_W - $bits(ctt_pkg::out_item_t)){1'b0}}, out_r};

endmodule

// File: rtl/core/ctt_checker.sv
// Port-level checker for the TCP connection tracker, bound to the top level.
module ctt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ctt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ctt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result transaction changed while stalled.");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49] |-> out_tdata[48:0] == 49'd0)
    else $error("Table-full result carries other fields.");

  a_became_est: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> out_tdata[10:9] == ctt_pkg::ST_EST)
    else $error("Newly established connection not in established state.");

  a_cont_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15] |-> out_tdata[0] && out_tdata[10:9] == ctt_pkg::ST_EST
      && !out_tdata[48])
    else $error("Continuation reported outside an established hit.");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind tcp_connection_tracker_top ctt_checker u_ctt_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench of the TCP connection tracker with a built-in table predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ctt_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ctt_pkg::OUT_TDATA_W-1:0] out_tdata;

  tcp_connection_tracker_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ctt_pkg::in_item_t pkt_q[$];
  ctt_pkg::out_item_t verdict_q[$];
  int errors = 0;
  int n_hits = 0, n_creates = 0, n_full = 0, n_est = 0, n_cont = 0, n_fin = 0;

  // Predictor copy of the connection table.
  logic        tbl_vld[ctt_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_a[ctt_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_b[ctt_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_ports[ctt_pkg::TABLE_ENTRIES];
  logic [1:0]  tbl_st[ctt_pkg::TABLE_ENTRIES];
  logic [1:0]  tbl_dir[ctt_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_s1[ctt_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_s2[ctt_pkg::TABLE_ENTRIES];
  logic        cont_state;

  function automatic ctt_pkg::out_item_t track_packet(ctt_pkg::in_item_t p);
    ctt_pkg::out_item_t r;
    logic [31:0] fwd, rev;
    int idx;
    logic hit, second, found, became, cont, fin_seen, same_dir;
    logic [1:0] nst, ndir;
    logic [31:0] h1, h2;
    r = '0;
    fwd = {p.src_port, p.dst_port};
    rev = {p.dst_port, p.src_port};
    idx = 0; hit = 0; second = 0; became = 0; cont = 0; fin_seen = 0; found = 0;
    for (int i = 0; i < ctt_pkg::TABLE_ENTRIES && !hit; i++) begin
      if (tbl_vld[i]) begin
        if (tbl_a[i] == p.src_addr && tbl_b[i] == p.dst_addr && tbl_ports[i] == fwd) begin
          hit = 1; idx = i;
        end else if (tbl_a[i] == p.dst_addr && tbl_b[i] == p.src_addr &&
                     tbl_ports[i] == rev) begin
          hit = 1; second = 1; idx = i;
        end
      end
    end
    if (hit) begin
      same_dir = (tbl_dir[idx] == {1'b0, p.direction});
      case (tbl_st[idx])
        ctt_pkg::ST_SYN: begin
          if (!same_dir && p.syn_flag && p.ack_flag) begin
            tbl_st[idx] = ctt_pkg::ST_SYNACK;
            tbl_s1[idx] = tbl_s1[idx] + 32'd1;
            tbl_s2[idx] = p.seq_num;
          end
        end
        ctt_pkg::ST_SYNACK: begin
          if (same_dir && !p.syn_flag && p.ack_flag) begin
            tbl_st[idx] = ctt_pkg::ST_EST;
            tbl_s2[idx] = tbl_s2[idx] + 32'd1;
            became = 1;
          end
        end
        ctt_pkg::ST_EST: begin
          if (p.captured_len < p.payload_len) begin
            cont_state = 1; cont = 1;
          end else begin
            cont_state = 0;
            if (second) tbl_s2[idx] = p.seq_num + 32'(p.payload_len);
            else tbl_s1[idx] = p.seq_num + 32'(p.payload_len);
            fin_seen = p.fin_flag;
          end
        end
        default: ;
      endcase
    end else begin
      for (int i = 0; i < ctt_pkg::TABLE_ENTRIES && !found; i++) begin
        if (!tbl_vld[i]) begin
          idx = i; found = 1;
        end
      end
      if (!found) begin
        r.table_full = 1;
        return r;
      end
      if (p.syn_flag && !p.ack_flag) begin
        second = 0; ndir = {1'b0, p.direction}; nst = ctt_pkg::ST_SYN; h1 = p.seq_num;
        h2 = '0;
      end else if (p.syn_flag) begin
        second = 1; ndir = {1'b0, ~p.direction}; nst = ctt_pkg::ST_SYNACK; h1 = p.ack_num;
        h2 = p.seq_num;
      end else if (p.ack_flag) begin
        second = !p.direction; ndir = {1'b0, p.direction}; nst = ctt_pkg::ST_EST;
        h1 = p.seq_num; h2 = p.ack_num;
      end else begin
        second = !p.direction; ndir = ctt_pkg::DIR_UNKNOWN; nst = ctt_pkg::ST_EST;
        h1 = p.ack_num; h2 = p.seq_num;
      end
      tbl_vld[idx] = 1;
      tbl_a[idx] = second ? p.dst_addr : p.src_addr;
      tbl_b[idx] = second ? p.src_addr : p.dst_addr;
      tbl_ports[idx] = second ? rev : fwd;
      tbl_st[idx] = nst;
      tbl_dir[idx] = ndir;
      tbl_s1[idx] = h1;
      tbl_s2[idx] = h2;
      became = (nst == ctt_pkg::ST_EST);
    end
    r.hit = hit;
    r.entry_index = 8'(idx);
    r.conn_state = tbl_st[idx];
    r.conn_direction = tbl_dir[idx];
    r.second_half = second;
    r.became_established = became;
    r.continuation = cont;
    r.next_seq = second ? tbl_s2[idx] : tbl_s1[idx];
    r.fin_seen = fin_seen;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Stimulus helpers and a pool of known connection tuples.
  logic [31:0] pool_a[$], pool_b[$];
  logic [15:0] pool_p[$], pool_q[$];
  logic        pool_d[$];

  task automatic add_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
                         logic dir, logic syn, logic ack, logic fin, logic [31:0] seq,
                         logic [31:0] ackn, logic [15:0] plen, logic [15:0] clen);
    ctt_pkg::in_item_t p;
    p.src_addr = sa; p.dst_addr = da; p.src_port = sp; p.dst_port = dp;
    p.direction = dir; p.syn_flag = syn; p.ack_flag = ack; p.fin_flag = fin;
    p.seq_num = seq; p.ack_num = ackn; p.payload_len = plen; p.captured_len = clen;
    pkt_q.push_back(p);
  endtask

  task automatic add_data(int k, logic rev);
    logic [15:0] plen, clen;
    plen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    case ($urandom_range(0, 3))
      0: clen = 16'($urandom_range(0, plen));
      1: clen = 16'($urandom);
      default: clen = plen;
    endcase
    if (rev)
      add_pkt(pool_b[k], pool_a[k], pool_q[k], pool_p[k], ~pool_d[k], 1'b0, 1'b1,
              $urandom_range(0, 7) == 0, $urandom, $urandom, plen, clen);
    else
      add_pkt(pool_a[k], pool_b[k], pool_p[k], pool_q[k], pool_d[k], 1'b0, 1'b1,
              $urandom_range(0, 7) == 0, $urandom, $urandom, plen, clen);
  endtask

  // Driver: bursts of transactions separated by random gaps.
  logic in_fire = 1'b0;
  int gap_left = 0, burst_left = 0;

  always @(negedge clk) begin
    logic nv;
    ctt_pkg::in_item_t np;
    nv = in_tvalid;
    np = ctt_pkg::in_item_t'(in_tdata[$bits(ctt_pkg::in_item_t)-1:0]);
    if (rst_n && (!in_tvalid || in_fire)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pkt_q.size() > 0) begin
        np = pkt_q.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= ctt_pkg::IN_TDATA_W'(np);
  end

  // Receiver: stall pattern switches in turn between always ready, random, sparse and mostly ready modes.
  int rx_cycle = 0;
  always @(negedge clk) begin
    int mode;
    logic rdy;
    rx_cycle++;
    mode = (rx_cycle / 300) % 4;
    case (mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 1) == 1);
      2: rdy = (rx_cycle % 5 == 0);
      default: rdy = ($urandom_range(0, 9) != 0);
    endcase
    out_tready <= rdy;
  end

  // Prediction on input acceptance, checking on output acceptance.
  int idle_cycles = 0;
  always @(posedge clk) begin
    ctt_pkg::out_item_t got, want;
    in_fire <= in_tvalid && in_tready;
    if (in_tvalid && in_tready)
      verdict_q.push_back(track_packet(
        ctt_pkg::in_item_t'(in_tdata[$bits(ctt_pkg::in_item_t)-1:0])));
    if (out_tvalid && out_tready) begin
      got = ctt_pkg::out_item_t'(out_tdata[$bits(ctt_pkg::out_item_t)-1:0]);
      if (verdict_q.size() == 0) begin
        report("unexpected result", 32'(got), 32'd0);
      end else begin
        want = verdict_q.pop_front();
        n_hits += want.hit;
        n_full += want.table_full;
        n_creates += !want.hit && !want.table_full;
        n_est += want.became_established;
        n_cont += want.continuation;
        n_fin += want.fin_seen;
        if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
        if (got.entry_index !== want.entry_index)
          report("entry_index", 32'(got.entry_index), 32'(want.entry_index));
        if (got.conn_state !== want.conn_state)
          report("conn_state", 32'(got.conn_state), 32'(want.conn_state));
        if (got.conn_direction !== want.conn_direction)
          report("conn_direction", 32'(got.conn_direction), 32'(want.conn_direction));
        if (got.second_half !== want.second_half)
          report("second_half", 32'(got.second_half), 32'(want.second_half));
        if (got.became_established !== want.became_established)
          report("became_established", 32'(got.became_established),
                 32'(want.became_established));
        if (got.continuation !== want.continuation)
          report("continuation", 32'(got.continuation), 32'(want.continuation));
        if (got.next_seq !== want.next_seq) report("next_seq", got.next_seq, want.next_seq);
        if (got.fin_seen !== want.fin_seen)
          report("fin_seen", 32'(got.fin_seen), 32'(want.fin_seen));
        if (got.table_full !== want.table_full)
          report("table_full", 32'(got.table_full), 32'(want.table_full));
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", verdict_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int k, n;
    for (int i = 0; i < ctt_pkg::TABLE_ENTRIES; i++) tbl_vld[i] = 1'b0;
    cont_state = 1'b0;

    // Directed: full handshake, data on both halves, partial capture, wrap.
    add_pkt(32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 1'b0, 1'b1, 1'b0, 1'b0,
            32'h100, 32'h0, 16'd0, 16'd0);
    add_pkt(32'hC0A80001, 32'h0A000001, 16'd80, 16'd1234, 1'b1, 1'b1, 1'b1, 1'b0,
            32'h900, 32'h101, 16'd0, 16'd0);
    add_pkt(32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 1'b1, 1'b0, 1'b1, 1'b0,
            32'h101, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 1'b0, 1'b1, 1'b0, 1'b0,
            32'h5, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 1'b0, 1'b0, 1'b1, 1'b0,
            32'h0, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 1'b0, 1'b0, 1'b1, 1'b0,
            32'h101, 32'h0, 16'd100, 16'd100);
    add_pkt(32'hC0A80001, 32'h0A000001, 16'd80, 16'd1234, 1'b1, 1'b0, 1'b1, 1'b0,
            32'h901, 32'h0, 16'd50, 16'd20);
    add_pkt(32'hC0A80001, 32'h0A000001, 16'd80, 16'd1234, 1'b1, 1'b0, 1'b1, 1'b1,
            32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'hFFFF);
    // Creation from syn-ack, ack-only and neither-flag packets, extreme fields.
    add_pkt(32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0, 1'b1, 1'b1, 1'b1, 1'b1,
            32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'h0);
    add_pkt(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0,
            32'h0, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h01020304, 32'h05060708, 16'd7, 16'd9, 1'b1, 1'b0, 1'b1, 1'b0,
            32'h11, 32'h22, 16'd0, 16'd0);
    add_pkt(32'h0B0B0B0B, 32'h0C0C0C0C, 16'd3, 16'd4, 1'b0, 1'b0, 1'b0, 1'b1,
            32'h33, 32'h44, 16'd10, 16'd10);
    add_pkt(32'h0D0D0D0D, 32'h0E0E0E0E, 16'd5, 16'd6, 1'b1, 1'b0, 1'b0, 1'b0,
            32'h55, 32'h66, 16'd0, 16'd0);
    // A tuple equal to its own reverse.
    add_pkt(32'h7F000001, 32'h7F000001, 16'd22, 16'd22, 1'b0, 1'b1, 1'b0, 1'b0,
            32'h1000, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h7F000001, 32'h7F000001, 16'd22, 16'd22, 1'b1, 1'b1, 1'b1, 1'b0,
            32'h2000, 32'h0, 16'd0, 16'd0);
    // Ignored hits in the syn and syn-ack states.
    add_pkt(32'h0A0A0A0A, 32'h14141414, 16'd100, 16'd200, 1'b1, 1'b1, 1'b0, 1'b0,
            32'h77, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h0A0A0A0A, 32'h14141414, 16'd100, 16'd200, 1'b1, 1'b1, 1'b1, 1'b0,
            32'h78, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h14141414, 32'h0A0A0A0A, 16'd200, 16'd100, 1'b0, 1'b1, 1'b1, 1'b0,
            32'h88, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h0A0A0A0A, 32'h14141414, 16'd100, 16'd200, 1'b0, 1'b0, 1'b1, 1'b0,
            32'h79, 32'h0, 16'd0, 16'd0);
    add_pkt(32'h0A0A0A0A, 32'h14141414, 16'd100, 16'd200, 1'b1, 1'b1, 1'b1, 1'b0,
            32'h79, 32'h0, 16'd0, 16'd0);

    // Random: mostly handshakes and data on pooled tuples, the rest noise.
    while (pkt_q.size() < 2000) begin
      if (pool_a.size() == 0 || $urandom_range(0, 9) < 3) begin
        pool_a.push_back($urandom); pool_b.push_back($urandom);
        pool_p.push_back(16'($urandom)); pool_q.push_back(16'($urandom));
        pool_d.push_back(1'($urandom));
        k = pool_a.size() - 1;
        add_pkt(pool_a[k], pool_b[k], pool_p[k], pool_q[k], pool_d[k], 1'b1, 1'b0, 1'b0,
                $urandom, $urandom, 16'd0, 16'd0);
        add_pkt(pool_b[k], pool_a[k], pool_q[k], pool_p[k], ~pool_d[k], 1'b1, 1'b1, 1'b0,
                $urandom, $urandom, 16'd0, 16'd0);
        add_pkt(pool_a[k], pool_b[k], pool_p[k], pool_q[k], pool_d[k], 1'b0, 1'b1, 1'b0,
                $urandom, $urandom, 16'd0, 16'd0);
      end else if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, pool_a.size() - 1);
        n = $urandom_range(1, 5);
        for (int j = 0; j < n; j++) add_data(k, 1'($urandom));
      end else begin
        add_pkt($urandom, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                16'($urandom), 16'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (pkt_q.size() > 0 || in_tvalid) @(posedge clk);
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d hits, %0d new connections, %0d table-full drops", n_hits,
             n_creates, n_full);
    $display("covered %0d handshakes completed, %0d partial captures, %0d fins", n_est,
             n_cont, n_fin);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
